>>> rtl/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

    // Fixed field widths of the command and result words.
    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 11;

    // Command kinds.
    localparam logic [KIND_W-1:0] KIND_PUT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POST = 2'd2;

    // Control characters and the blank fill character.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    // Tab stops fall on every eighth cell.
    localparam int TAB_STOP = 8;
    localparam int TAB_CNT_W = 4;

    // Uppercase hex digit characters.
    localparam logic [CHAR_W-1:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // Command word.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_code;
        logic [CELL_W-1:0] cell_index;
        logic [CHAR_W-1:0] post_code;
    } item_word_t;

    // Result word.
    typedef struct packed {
        logic [CELL_W-1:0] cursor_cell;
        logic [CHAR_W-1:0] cell_char;
        logic              scrolled;
    } result_word_t;

    // Sequencer to sweep engine.
    typedef struct packed {
        logic go;
    } sweep_cmd_t;

    // Sweep engine to sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } sweep_stat_t;

endpackage

>>> rtl/tccw_ram.sv
`timescale 1ns / 1ps

module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tccw_sweep.sv
`timescale 1ns / 1ps

module tccw_sweep #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int POST_CELLS = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tccw_pkg::sweep_cmd_t                cmd,
    output tccw_pkg::sweep_stat_t               stat,
    output logic                                we,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     waddr,
    output logic [tccw_pkg::CHAR_W-1:0]         wdata,
    output logic                                re,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     raddr,
    input  logic [tccw_pkg::CHAR_W-1:0]         rdata
);

    import tccw_pkg::*;

    localparam int TOTAL  = COLUMNS * ROWS;
    localparam int LIMIT  = TOTAL - POST_CELLS;
    localparam int START  = COLUMNS * (ROWS - 1) - POST_CELLS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int CNT_W  = $clog2(TOTAL + 1);

    typedef enum logic [3:0] {
        SW_CLEAR = 4'b0001,
        SW_IDLE  = 4'b0010,
        SW_COPY  = 4'b0100,
        SW_FLUSH = 4'b1000
    } sweep_state_t;

    sweep_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_copy_reg, pend_copy_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              below_start;

    assign below_start = (idx_reg < CNT_W'(START));

    // Sweep sequencing. The scroll reads the cell one row below and writes
    // it back in the following cycle; cells from the blank start on get spaces.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_copy_next  = pend_copy_reg;
        pend_addr_next  = pend_addr_reg;
        we              = 1'b0;
        waddr           = pend_addr_reg;
        wdata           = CH_BLANK;
        re              = 1'b0;
        raddr           = ADDR_W'(idx_reg + CNT_W'(COLUMNS));

        // Retire the write issued in the previous cycle.
        if (pend_valid_reg)
        begin
            we    = 1'b1;
            wdata = pend_copy_reg ? rdata : CH_BLANK;
        end

        case (state_reg)
            SW_CLEAR:
            begin
                we    = 1'b1;
                waddr = ADDR_W'(idx_reg);
                wdata = CH_BLANK;
                if (idx_reg == CNT_W'(TOTAL - 1))
                begin
                    idx_next   = '0;
                    state_next = SW_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            SW_IDLE:
            begin
                if (cmd.go)
                begin
                    idx_next   = '0;
                    state_next = SW_COPY;
                end
            end
            SW_COPY:
            begin
                re              = below_start;
                pend_valid_next = 1'b1;
                pend_copy_next  = below_start;
                pend_addr_next  = ADDR_W'(idx_reg);
                if (idx_reg == CNT_W'(LIMIT - 1))
                begin
                    state_next = SW_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            SW_FLUSH:
            begin
                pend_valid_next = 1'b0;
                idx_next        = '0;
                state_next      = SW_IDLE;
            end
            default:
            begin
                state_next = SW_IDLE;
            end
        endcase
    end

    // Control state; the sweep clears the screen straight out of reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SW_CLEAR;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Pending write payload.
    always_ff @(posedge clk)
    begin
        pend_copy_reg <= pend_copy_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign stat.busy = (state_reg != SW_IDLE);
    assign stat.done = (state_reg == SW_FLUSH);

endmodule

>>> rtl/text_console_char_writer_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                  Handshake
// --------  ---------------------  -------------------------------------------
// command   start, busy, item      word taken at a clock edge with start & !busy
// result    done, result           word valid for the one cycle done is high
//
// A character, or each space of a tab, is written in ST_WRITE; a screen read
// passes through ST_READ, a post code through ST_POST, and anything else
// finishes from ST_IDLE; the strobe is registered. A step that reaches the
// scroll limit starts a scroll over all but the post cells, one cell a cycle
// through the single write port. After reset a clearing pass writes spaces
// into all COLUMNS*ROWS cells with busy high. The receiver cannot stall.

module text_console_char_writer_unit #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int POST_CELLS = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tccw_pkg::item_word_t   item,
    output logic                   done,
    output tccw_pkg::result_word_t result
);

    import tccw_pkg::*;

    localparam int TOTAL  = COLUMNS * ROWS;
    localparam int LIMIT  = TOTAL - POST_CELLS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int CUR_W  = $clog2(TOTAL + 1);
    localparam int COL_W  = $clog2(COLUMNS);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WRITE  = 5'b00010,
        ST_SCROLL = 5'b00100,
        ST_READ   = 5'b01000,
        ST_POST   = 5'b10000
    } seq_state_t;

    seq_state_t             state_reg, state_next;
    logic [CUR_W-1:0]       cursor_reg, cursor_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [TAB_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic [CHAR_W-1:0]      low_digit_reg, low_digit_next;
    logic                   scrolled_reg, scrolled_next;
    logic                   out_valid_reg, out_valid_next;
    result_word_t           out_reg, out_next;

    logic                   accept;
    logic                   finish;
    logic [CHAR_W-1:0]      out_char;
    logic [CUR_W-1:0]       bump_pos;
    logic [COL_W-1:0]       bump_col;
    logic [CUR_W-1:0]       newline_pos;
    logic [CUR_W-1:0]       back_pos;
    logic [COL_W-1:0]       back_col;

    logic                   seq_we, seq_re;
    logic [ADDR_W-1:0]      seq_waddr, seq_raddr;
    logic [CHAR_W-1:0]      seq_wdata;

    logic                   sw_we, sw_re;
    logic [ADDR_W-1:0]      sw_waddr, sw_raddr;
    logic [CHAR_W-1:0]      sw_wdata;
    sweep_cmd_t             sw_cmd;
    sweep_stat_t            sw_stat;

    logic                   ram_we, ram_re;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [CHAR_W-1:0]      ram_wdata, ram_rdata;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE) || sw_stat.busy;

    // Cursor moves, with the column tracked alongside.
    always_comb
    begin
        bump_pos    = cursor_reg + CUR_W'(1);
        bump_col    = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + COL_W'(1);
        newline_pos = cursor_reg - CUR_W'(col_reg) + CUR_W'(COLUMNS);
        if (cursor_reg == '0)
        begin
            back_pos = '0;
            back_col = '0;
        end
        else
        begin
            back_pos = cursor_reg - CUR_W'(1);
            back_col = (col_reg == '0) ? COL_W'(COLUMNS - 1) : col_reg - COL_W'(1);
        end
    end

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        char_next      = char_reg;
        low_digit_next = low_digit_reg;
        scrolled_next  = scrolled_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        finish         = 1'b0;
        out_char       = '0;
        sw_cmd.go      = 1'b0;
        seq_we         = 1'b0;
        seq_waddr      = ADDR_W'(cursor_reg);
        seq_wdata      = char_reg;
        seq_re         = 1'b0;
        seq_raddr      = ADDR_W'(item.cell_index);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scrolled_next = 1'b0;
                    case (item.kind)
                        KIND_PUT:
                        begin
                            if (item.char_code == CH_NEWLINE)
                            begin
                                cursor_next = newline_pos;
                                col_next    = '0;
                                if (newline_pos >= CUR_W'(LIMIT))
                                begin
                                    cnt_next      = '0;
                                    scrolled_next = 1'b1;
                                    sw_cmd.go     = 1'b1;
                                    state_next    = ST_SCROLL;
                                end
                                else
                                begin
                                    finish = 1'b1;
                                end
                            end
                            else if (item.char_code == CH_TAB)
                            begin
                                cnt_next   = TAB_CNT_W'(TAB_STOP)
                                           - {1'b0, cursor_reg[2:0]};
                                char_next  = CH_BLANK;
                                state_next = ST_WRITE;
                            end
                            else if (item.char_code == CH_BACKSPACE)
                            begin
                                // Blank the cell behind the cursor and stay there.
                                seq_we      = 1'b1;
                                seq_waddr   = ADDR_W'(back_pos);
                                seq_wdata   = CH_BLANK;
                                cursor_next = back_pos;
                                col_next    = back_col;
                                finish      = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = TAB_CNT_W'(1);
                                char_next  = item.char_code;
                                state_next = ST_WRITE;
                            end
                        end
                        KIND_READ:
                        begin
                            if (int'(item.cell_index) < TOTAL)
                            begin
                                seq_re     = 1'b1;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        KIND_POST:
                        begin
                            seq_we         = 1'b1;
                            seq_waddr      = ADDR_W'(TOTAL - 2);
                            seq_wdata      = HEX_DIGITS[item.post_code[7:4]];
                            low_digit_next = HEX_DIGITS[item.post_code[3:0]];
                            state_next     = ST_POST;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                // One character per cycle unless a scroll intervenes; a scroll is taken between characters.
                seq_we      = 1'b1;
                cursor_next = bump_pos;
                col_next    = bump_col;
                cnt_next    = cnt_reg - TAB_CNT_W'(1);
                if (bump_pos >= CUR_W'(LIMIT))
                begin
                    scrolled_next = 1'b1;
                    sw_cmd.go     = 1'b1;
                    state_next    = ST_SCROLL;
                end
                else if (cnt_reg == TAB_CNT_W'(1))
                begin
                    finish = 1'b1;
                end
            end
            ST_SCROLL:
            begin
                if (sw_stat.done)
                begin
                    cursor_next = cursor_reg - CUR_W'(COLUMNS);
                    if (cnt_reg != '0)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                out_char = ram_rdata;
                finish   = 1'b1;
            end
            ST_POST:
            begin
                seq_we    = 1'b1;
                seq_waddr = ADDR_W'(TOTAL - 1);
                seq_wdata = low_digit_reg;
                finish    = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Load the result word at the end of a command.
        if (finish)
        begin
            state_next           = ST_IDLE;
            out_valid_next       = 1'b1;
            out_next.cursor_cell = CELL_W'(cursor_next);
            out_next.cell_char   = out_char;
            out_next.scrolled    = scrolled_next;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            scrolled_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            scrolled_reg  <= scrolled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        low_digit_reg <= low_digit_next;
        out_reg       <= out_next;
    end

    assign done   = out_valid_reg;
    assign result = out_reg;

    // Clear and scroll sweep engine.
    tccw_sweep #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .POST_CELLS (POST_CELLS)
    ) u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (sw_cmd),
        .stat  (sw_stat),
        .we    (sw_we),
        .waddr (sw_waddr),
        .wdata (sw_wdata),
        .re    (sw_re),
        .raddr (sw_raddr),
        .rdata (ram_rdata)
    );

    // The sweep owns the memory ports while it runs.
    always_comb
    begin
        if (sw_stat.busy)
        begin
            ram_we    = sw_we;
            ram_waddr = sw_waddr;
            ram_wdata = sw_wdata;
            ram_re    = sw_re;
            ram_raddr = sw_raddr;
        end
        else
        begin
            ram_we    = seq_we;
            ram_waddr = seq_waddr;
            ram_wdata = seq_wdata;
            ram_re    = seq_re;
            ram_raddr = seq_raddr;
        end
    end

    // Screen character memory.
    tccw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (TOTAL)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    // At rest the cursor never sits on the post cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> cursor_reg < CUR_W'(LIMIT))
        else $error("cursor at rest beyond the scroll limit");

    // The tracked column stays inside a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(COLUMNS - 1))
        else $error("column out of range");

    // The sweep runs only for the reset clear or a scroll.
    assert property (@(posedge clk) disable iff (!rst_n)
        sw_stat.busy |-> (state_reg == ST_SCROLL || state_reg == ST_IDLE))
        else $error("sweep active outside a scroll");

    // A reported cursor matches the cursor register.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.cursor_cell == CELL_W'(cursor_reg))
        else $error("result cursor differs from cursor register");
`endif

endmodule
